// ----- rtl/sdinit_pkg.sv -----
// Shared types, codes and constants of the SD card bring-up sequencer.
`timescale 1ns / 1ps

package sdinit_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_POWER_UP_RETRY = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ADDRESS_RETRY  = 1'b1;

  localparam logic [7:0] POWER_UP_RETRY_RESET = 8'd100;
  localparam logic [7:0] ADDRESS_RETRY_RESET  = 8'd10;

  // Input word actions
  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_RESULT = 1'b1;

  // Command completion status
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TIMEOUT = 3'd1;
  localparam logic [2:0] ST_ERROR   = 3'd3;

  // Response kinds
  localparam logic [2:0] RK_NONE = 3'd0;
  localparam logic [2:0] RK_R1   = 3'd1;
  localparam logic [2:0] RK_R1B  = 3'd2;
  localparam logic [2:0] RK_R2   = 3'd3;
  localparam logic [2:0] RK_R3   = 3'd4;
  localparam logic [2:0] RK_R6   = 3'd5;
  localparam logic [2:0] RK_R7   = 3'd6;

  // Command indexes
  localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
  localparam logic [5:0] CMD_ALL_CID     = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA    = 6'd3;
  localparam logic [5:0] CMD_BUS_WIDTH   = 6'd6;
  localparam logic [5:0] CMD_SELECT      = 6'd7;
  localparam logic [5:0] CMD_IF_COND     = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD    = 6'd9;
  localparam logic [5:0] CMD_BLOCKLEN    = 6'd16;
  localparam logic [5:0] CMD_OP_COND     = 6'd41;

  // Failure codes
  localparam logic [3:0] FAIL_NONE     = 4'd0;
  localparam logic [3:0] FAIL_RESET    = 4'd1;
  localparam logic [3:0] FAIL_PATTERN  = 4'd2;
  localparam logic [3:0] FAIL_VOLTAGE  = 4'd3;
  localparam logic [3:0] FAIL_EXCHANGE = 4'd4;
  localparam logic [3:0] FAIL_ACMD41   = 4'd5;
  localparam logic [3:0] FAIL_POWERUP  = 4'd6;
  localparam logic [3:0] FAIL_CID      = 4'd7;
  localparam logic [3:0] FAIL_RCA      = 4'd8;
  localparam logic [3:0] FAIL_RCAZERO  = 4'd9;
  localparam logic [3:0] FAIL_CSD      = 4'd10;
  localparam logic [3:0] FAIL_SELECT   = 4'd11;
  localparam logic [3:0] FAIL_WIDTH    = 4'd12;
  localparam logic [3:0] FAIL_BLOCKLEN = 4'd13;

  // Argument and response bit patterns
  localparam logic [7:0]  CHECK_PATTERN = 8'haa;
  localparam logic [31:0] IF_COND_ARG   = 32'h0000_0100 | 32'(CHECK_PATTERN);
  localparam logic [31:0] VOLT_MASK     = 32'h0000_0f00;
  localparam logic [31:0] VOLT_OK       = 32'h0000_0100;
  localparam logic [31:0] VOLT_WINDOW   = 32'h00ff_8000;
  localparam logic [31:0] HCS_BIT       = 32'h4000_0000;
  localparam logic [31:0] READY_BIT     = 32'h8000_0000;
  localparam logic [31:0] BUS_4BIT_ARG  = 32'h0000_0002;
  localparam logic [31:0] BLOCK_LEN     = 32'd512;

  // Bus clock dividers off the 100 MHz host clock
  localparam int unsigned HostClkHz = 100 * 1000 * 1000;
  localparam logic [7:0] DIV_SLOW = 8'(HostClkHz / (400 * 1000) - 1);
  localparam logic [7:0] DIV_STD  = 8'(HostClkHz / (25 * 1000 * 1000) - 1);
  localparam logic [7:0] DIV_FAST = 8'(HostClkHz / (50 * 1000 * 1000) - 1);

  // Sequence phase, one-hot
  typedef enum logic [12:0] {
    PH_IDLE   = 13'h0001,
    PH_RESET0 = 13'h0002,
    PH_CMD8   = 13'h0004,
    PH_RESET1 = 13'h0008,
    PH_ACMD41 = 13'h0010,
    PH_CMD2   = 13'h0020,
    PH_CMD3   = 13'h0040,
    PH_CMD9   = 13'h0080,
    PH_CMD7   = 13'h0100,
    PH_ACMD6  = 13'h0200,
    PH_CMD16  = 13'h0400,
    PH_DONE   = 13'h0800,
    PH_FAILED = 13'h1000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic        version_two;
    logic        high_capacity;
    logic        mmc_guess;
    logic [15:0] relative_address;
    logic [7:0]  retry_count;
    logic        fast_clock;
  } card_state_t;

  typedef struct packed {
    logic [5:0]  cmd_index;
    logic [31:0] cmd_argument;
    logic [2:0]  response_kind;
    logic        app_specific;
    logic [7:0]  clock_divider;
    logic        high_speed;
    logic        finished;
    logic [3:0]  fail_code;
    logic        card_is_sdhc;
    logic        card_is_v2;
    logic [15:0] card_address;
    logic        maybe_mmc;
  } result_t;

  typedef struct packed {
    logic        action;
    logic [2:0]  cmd_status;
    logic [31:0] card_response;
  } request_t;

endpackage

// ----- rtl/sdinit_req_if.sv -----
// Request channel: start and command-completion words into the sequencer.
`timescale 1ns / 1ps

interface sdinit_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [2:0]  cmd_status;
  logic [31:0] card_response;

  modport source (output valid, action, cmd_status, card_response, input ready);
  modport sink   (input valid, action, cmd_status, card_response, output ready);
endinterface

// ----- rtl/sdinit_cmd_if.sv -----
// Command channel: next-command and status words out of the sequencer.
`timescale 1ns / 1ps

interface sdinit_cmd_if;
  logic        valid;
  logic        ready;
  logic [5:0]  cmd_index;
  logic [31:0] cmd_argument;
  logic [2:0]  response_kind;
  logic        app_specific;
  logic [7:0]  clock_divider;
  logic        high_speed;
  logic        finished;
  logic [3:0]  fail_code;
  logic        card_is_sdhc;
  logic        card_is_v2;
  logic [15:0] card_address;
  logic        maybe_mmc;

  modport source (
    output valid, cmd_index, cmd_argument, response_kind, app_specific, clock_divider,
           high_speed, finished, fail_code, card_is_sdhc, card_is_v2, card_address,
           maybe_mmc,
    input  ready
  );
  modport sink (
    input  valid, cmd_index, cmd_argument, response_kind, app_specific, clock_divider,
           high_speed, finished, fail_code, card_is_sdhc, card_is_v2, card_address,
           maybe_mmc,
    output ready
  );
endinterface

// ----- rtl/sd_card_init_sequencer_top.sv -----
// SD card bring-up sequencer: top level with input, state and result registers.
`timescale 1ns / 1ps

// Feed one start word, then one word per finished command (status and the
// 32-bit short response); each word yields the next command to issue, or a
// final done or numbered failure word. A start word restarts the sequence at
// any time; a result word while idle, done or failed yields nothing. The block
// takes one word per cycle: a word is captured in the input register, the
// phase logic runs combinationally against the card state, and the command
// is registered in the result register. A held result stalls the input side
// only once the input register is also full. The user must write retry limits
// through the configuration port while idle; the block does not enforce this.

module sd_card_init_sequencer_top import sdinit_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  sdinit_req_if.sink         req_i,
  sdinit_cmd_if.source       cmd_o
);

  logic        in_valid_q;
  request_t    in_word_q;
  logic        advance;
  logic        out_valid_q;
  result_t     out_word_q;
  card_state_t state_q;
  card_state_t state_d;
  result_t     step_result;
  logic        step_emit;
  logic [7:0]  power_up_limit_q;
  logic [7:0]  address_limit_q;

  // Move the input word on when the result register is free
  assign advance     = in_valid_q && (!out_valid_q || cmd_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_up_limit_q <= POWER_UP_RETRY_RESET;
      address_limit_q  <= ADDRESS_RETRY_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_POWER_UP_RETRY: power_up_limit_q <= cfg_data_i;
        CFG_ADDRESS_RETRY:  address_limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_word_q.action        <= req_i.action;
      in_word_q.cmd_status    <= req_i.cmd_status;
      in_word_q.card_response <= req_i.card_response;
    end
  end

  sdinit_step u_step (
    .state_i          (state_q),
    .req_i            (in_word_q),
    .power_up_limit_i (power_up_limit_q),
    .address_limit_i  (address_limit_q),
    .state_o          (state_d),
    .result_o         (step_result),
    .emit_o           (step_emit)
  );

  // Card state, updated as each word is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase            <= PH_IDLE;
      state_q.version_two      <= 1'b0;
      state_q.high_capacity    <= 1'b0;
      state_q.mmc_guess        <= 1'b0;
      state_q.relative_address <= '0;
      state_q.retry_count      <= '0;
      state_q.fast_clock       <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step_emit;
    end else if (cmd_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (advance && step_emit) begin
      out_word_q <= step_result;
    end
  end

  assign cmd_o.valid         = out_valid_q;
  assign cmd_o.cmd_index     = out_word_q.cmd_index;
  assign cmd_o.cmd_argument  = out_word_q.cmd_argument;
  assign cmd_o.response_kind = out_word_q.response_kind;
  assign cmd_o.app_specific  = out_word_q.app_specific;
  assign cmd_o.clock_divider = out_word_q.clock_divider;
  assign cmd_o.high_speed    = out_word_q.high_speed;
  assign cmd_o.finished      = out_word_q.finished;
  assign cmd_o.fail_code     = out_word_q.fail_code;
  assign cmd_o.card_is_sdhc  = out_word_q.card_is_sdhc;
  assign cmd_o.card_is_v2    = out_word_q.card_is_v2;
  assign cmd_o.card_address  = out_word_q.card_address;
  assign cmd_o.maybe_mmc     = out_word_q.maybe_mmc;

  // Input side stalls only with both registers full and the result held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (in_valid_q && out_valid_q && !cmd_o.ready))
    else $error("input stalled without a full pipeline");

  // A waiting input word holds until it is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_word_q)))
    else $error("waiting input word lost or changed");

  // The fast bus clock is chosen only once the card has passed CMD9
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.fast_clock |-> (state_q.phase == PH_CMD7 || state_q.phase == PH_ACMD6 ||
                            state_q.phase == PH_CMD16 || state_q.phase == PH_DONE ||
                            state_q.phase == PH_FAILED))
    else $error("fast clock outside the late phases");

  // High speed goes with the fast divider on a high-capacity card
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.valid && cmd_o.high_speed) |-> (cmd_o.card_is_sdhc &&
                                           cmd_o.clock_divider == DIV_FAST))
    else $error("high speed without fast divider");

  // A done word carries no failure and no command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.valid && cmd_o.finished) |-> (cmd_o.fail_code == FAIL_NONE &&
                                         cmd_o.response_kind == RK_NONE))
    else $error("done word with failure or command");

endmodule

// ----- rtl/sdinit_step.sv -----
// Next-state and next-command logic of the bring-up sequence for one word.
`timescale 1ns / 1ps

module sdinit_step import sdinit_pkg::*; (
  input  card_state_t state_i,
  input  request_t    req_i,
  input  logic [7:0]  power_up_limit_i,
  input  logic [7:0]  address_limit_i,
  output card_state_t state_o,
  output result_t     result_o,
  output logic        emit_o
);

  logic [5:0]  idx;
  logic [31:0] arg;
  logic [2:0]  kind;
  logic        app;
  logic        fin;
  logic [3:0]  fail;
  logic        st_ok;
  logic [31:0] resp;
  card_state_t nxt;

  assign st_ok = (req_i.cmd_status == ST_OK);
  assign resp  = req_i.card_response;

  always_comb begin
    nxt    = state_i;
    idx    = CMD_GO_IDLE;
    arg    = '0;
    kind   = RK_NONE;
    app    = 1'b0;
    fin    = 1'b0;
    fail   = FAIL_NONE;
    emit_o = 1'b1;

    if (req_i.action == ACT_START) begin
      // Clear card facts and restart with CMD0
      nxt.phase            = PH_RESET0;
      nxt.version_two      = 1'b0;
      nxt.high_capacity    = 1'b0;
      nxt.mmc_guess        = 1'b0;
      nxt.relative_address = '0;
      nxt.retry_count      = '0;
      nxt.fast_clock       = 1'b0;
    end else begin
      unique case (state_i.phase) inside
        PH_RESET0, PH_RESET1: begin
          if (!st_ok) begin
            nxt.phase = PH_FAILED;
            fail      = FAIL_RESET;
          end else if (state_i.phase == PH_RESET0) begin
            nxt.phase = PH_CMD8;
            idx       = CMD_IF_COND;
            arg       = IF_COND_ARG;
            kind      = RK_R7;
          end else begin
            nxt.retry_count = '0;
            nxt.phase       = PH_ACMD41;
            idx             = CMD_OP_COND;
            arg             = VOLT_WINDOW;
            kind            = RK_R3;
            app             = 1'b1;
          end
        end
        PH_CMD8: begin
          if (st_ok) begin
            nxt.version_two = 1'b1;
            if (resp[7:0] != CHECK_PATTERN) begin
              nxt.phase = PH_FAILED;
              fail      = FAIL_PATTERN;
            end else if ((resp & VOLT_MASK) != VOLT_OK) begin
              nxt.phase = PH_FAILED;
              fail      = FAIL_VOLTAGE;
            end else begin
              nxt.retry_count = '0;
              nxt.phase       = PH_ACMD41;
              idx             = CMD_OP_COND;
              arg             = VOLT_WINDOW | HCS_BIT;
              kind            = RK_R3;
              app             = 1'b1;
            end
          end else if (req_i.cmd_status == ST_TIMEOUT || req_i.cmd_status == ST_ERROR) begin
            // Older card: fall back to a second CMD0
            nxt.phase = PH_RESET1;
          end else begin
            nxt.phase = PH_FAILED;
            fail      = FAIL_EXCHANGE;
          end
        end
        PH_ACMD41: begin
          if (!st_ok) begin
            if (req_i.cmd_status == ST_TIMEOUT && !state_i.version_two) begin
              nxt.mmc_guess = 1'b1;
            end
            nxt.phase = PH_FAILED;
            fail      = FAIL_ACMD41;
          end else if ((resp & VOLT_WINDOW) == '0) begin
            nxt.phase = PH_FAILED;
            fail      = FAIL_VOLTAGE;
          end else if ((resp & READY_BIT) != '0) begin
            nxt.high_capacity = ((resp & HCS_BIT) != '0);
            nxt.phase         = PH_CMD2;
            idx               = CMD_ALL_CID;
            kind              = RK_R2;
          end else if (state_i.retry_count >= power_up_limit_i) begin
            nxt.phase = PH_FAILED;
            fail      = FAIL_POWERUP;
          end else begin
            // Card still busy: poll again
            nxt.retry_count = state_i.retry_count + 8'd1;
            idx             = CMD_OP_COND;
            arg             = VOLT_WINDOW | (state_i.version_two ? HCS_BIT : '0);
            kind            = RK_R3;
            app             = 1'b1;
          end
        end
        PH_CMD2: begin
          if (!st_ok) begin
            nxt.phase = PH_FAILED;
            fail      = FAIL_CID;
          end else begin
            nxt.retry_count = '0;
            nxt.phase       = PH_CMD3;
            idx             = CMD_SEND_RCA;
            kind            = RK_R6;
          end
        end
        PH_CMD3: begin
          if (!st_ok) begin
            nxt.phase = PH_FAILED;
            fail      = FAIL_RCA;
          end else begin
            nxt.relative_address = resp[31:16];
            if (resp[31:16] != '0) begin
              nxt.phase = PH_CMD9;
              idx       = CMD_SEND_CSD;
              arg       = {resp[31:16], 16'h0000};
              kind      = RK_R2;
            end else if (state_i.retry_count >= address_limit_i) begin
              nxt.phase = PH_FAILED;
              fail      = FAIL_RCAZERO;
            end else begin
              nxt.retry_count = state_i.retry_count + 8'd1;
              idx             = CMD_SEND_RCA;
              kind            = RK_R6;
            end
          end
        end
        PH_CMD9: begin
          if (!st_ok) begin
            nxt.phase = PH_FAILED;
            fail      = FAIL_CSD;
          end else begin
            nxt.fast_clock = 1'b1;
            nxt.phase      = PH_CMD7;
            idx            = CMD_SELECT;
            arg            = {state_i.relative_address, 16'h0000};
            kind           = RK_R1B;
          end
        end
        PH_CMD7: begin
          if (!st_ok) begin
            nxt.phase = PH_FAILED;
            fail      = FAIL_SELECT;
          end else begin
            nxt.phase = PH_ACMD6;
            idx       = CMD_BUS_WIDTH;
            arg       = BUS_4BIT_ARG;
            kind      = RK_R1;
            app       = 1'b1;
          end
        end
        PH_ACMD6: begin
          if (!st_ok) begin
            nxt.phase = PH_FAILED;
            fail      = FAIL_WIDTH;
          end else begin
            nxt.phase = PH_CMD16;
            idx       = CMD_BLOCKLEN;
            arg       = BLOCK_LEN;
            kind      = RK_R1;
          end
        end
        PH_CMD16: begin
          if (!st_ok) begin
            nxt.phase = PH_FAILED;
            fail      = FAIL_BLOCKLEN;
          end else begin
            nxt.phase = PH_DONE;
            fin       = 1'b1;
          end
        end
        default: begin
          // Idle, done or failed: drop the word
          emit_o = 1'b0;
        end
      endcase
    end
  end

  // Build the result word from the updated card facts
  always_comb begin
    result_o.cmd_index     = idx;
    result_o.cmd_argument  = arg;
    result_o.response_kind = kind;
    result_o.app_specific  = app;
    result_o.clock_divider = nxt.fast_clock ? (nxt.high_capacity ? DIV_FAST : DIV_STD)
                                            : DIV_SLOW;
    result_o.high_speed    = nxt.fast_clock && nxt.high_capacity;
    result_o.finished      = fin;
    result_o.fail_code     = fail;
    result_o.card_is_sdhc  = nxt.high_capacity;
    result_o.card_is_v2    = nxt.version_two;
    result_o.card_address  = nxt.relative_address;
    result_o.maybe_mmc     = nxt.mmc_guess;
  end

  assign state_o = nxt;

endmodule
